// ===== hw/rtl/sbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

   localparam int WORD_W      = 32;
   localparam int HASH_WORDS  = 8;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS      = 64;
   localparam int ROUND_W     = $clog2(ROUNDS);
   localparam int COUNT_W     = $clog2(BLOCK_WORDS);
   localparam int QUEUE_DEPTH = 2;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [HASH_WORDS-1:0][WORD_W-1:0] hash_type;
   typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_type;

   // one gathered block on its way to the compression core
   typedef struct packed {
      logic      reload;
      block_type words;
   } block_job_type;

   // fill status of the block queue
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // word 0 sits in the lowest bits
   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha256_block_compress_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                     beat taken when
// req       req_push req_full req_msg_word            req_push & !req_full
//           req_begin_message
// rsp       rsp_empty rsp_pop rsp_hash_a..rsp_hash_h  rsp_pop & !rsp_empty
//
// one word beat per cycle is taken while the block queue has room; the
// compression core works a block in steps (load, 64 rounds, final add), so
// a steady stream is limited by the one-round-per-cycle compression loop.
// reset is synchronous and loads the initial hash; no clearing pass.
// req_full rises only on a block's closing word while the queue is full;
// the core holds its final add while a result still waits on rsp.
module sha256_block_compress_unit #(
   parameter int QUEUE_DEPTH = sbc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire sbc_pkg::word_type req_msg_word,
   input  wire logic              req_begin_message,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output sbc_pkg::word_type      rsp_hash_a,
   output sbc_pkg::word_type      rsp_hash_b,
   output sbc_pkg::word_type      rsp_hash_c,
   output sbc_pkg::word_type      rsp_hash_d,
   output sbc_pkg::word_type      rsp_hash_e,
   output sbc_pkg::word_type      rsp_hash_f,
   output sbc_pkg::word_type      rsp_hash_g,
   output sbc_pkg::word_type      rsp_hash_h
);

   sbc_pkg::queue_status_type q_status;
   sbc_pkg::block_job_type    push_job;
   sbc_pkg::block_job_type    head_job;
   logic                      q_push;
   logic                      q_pop;
   logic                      rsp_valid;
   sbc_pkg::hash_type         rsp_hash;

   sbc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_msg_word      (req_msg_word),
      .req_begin_message (req_begin_message),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_job             (push_job)
   );

   sbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   sbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (rsp_pop),
      .rsp_hash  (rsp_hash)
   );

   // result words out on their own ports
   assign rsp_empty  = !rsp_valid;
   assign rsp_hash_a = rsp_hash[0];
   assign rsp_hash_b = rsp_hash[1];
   assign rsp_hash_c = rsp_hash[2];
   assign rsp_hash_d = rsp_hash[3];
   assign rsp_hash_e = rsp_hash[4];
   assign rsp_hash_f = rsp_hash[5];
   assign rsp_hash_g = rsp_hash[6];
   assign rsp_hash_h = rsp_hash[7];

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire sbc_pkg::word_type         req_msg_word,
   input  wire logic                      req_begin_message,
   input  wire sbc_pkg::queue_status_type q_status,
   output logic                           q_push,
   output sbc_pkg::block_job_type         q_job
);

   localparam int LAST_IDX = sbc_pkg::BLOCK_WORDS - 1;

   logic [sbc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        reload_ff, reload_in;
   sbc_pkg::word_type           words_ff [LAST_IDX];
   logic [sbc_pkg::COUNT_W-1:0] idx;
   logic                        accept;
   logic                        last_word;

   // hold off only when this beat could close a block and the queue has no room
   assign req_full  = (count_ff == sbc_pkg::COUNT_W'(LAST_IDX)) && q_status.full;
   assign accept    = req_push && !req_full;
   assign idx       = req_begin_message ? '0 : count_ff;
   assign last_word = (idx == sbc_pkg::COUNT_W'(LAST_IDX));
   assign q_push    = accept && last_word;

   // word position and reload flag of the block being gathered
   always_comb begin
      count_in  = count_ff;
      reload_in = reload_ff;
      if (accept) begin
         if (last_word) begin
            count_in = '0;
         end else begin
            count_in = idx + sbc_pkg::COUNT_W'(1);
         end
         if (idx == '0) begin
            reload_in = req_begin_message;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         reload_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         reload_ff <= reload_in;
      end
   end

   // gather words 0 to 14; word 15 goes straight to the queue
   always_ff @(posedge clock) begin
      if (accept && !last_word) begin
         words_ff[idx] <= req_msg_word;
      end
   end

   // assemble the finished block
   always_comb begin
      q_job.reload = reload_ff;
      for (int i = 0; i < LAST_IDX; i++) begin
         q_job.words[i] = words_ff[i];
      end
      q_job.words[LAST_IDX] = req_msg_word;
   end

   a_full_only_at_last: assert property (@(posedge clock) disable iff (reset)
      req_full |-> (count_ff == sbc_pkg::COUNT_W'(LAST_IDX)))
      else $error("input held off away from the closing word");

   a_push_accepted: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("block pushed into a full queue");

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shifting block queue, head always in slot 0; depth of two or more
module sbc_queue #(
   parameter int DEPTH = sbc_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire sbc_pkg::block_job_type push_job,
   input  wire logic                   pop,
   output sbc_pkg::block_job_type      head_job,
   output sbc_pkg::queue_status_type   status
);

   localparam int CW = $clog2(DEPTH + 1);

   sbc_pkg::block_job_type slot_ff [DEPTH];
   logic [CW-1:0]          count_ff, count_in;
   logic                   push_ok, pop_ok;
   logic [CW-1:0]          wr_pos;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign push_ok      = push && !status.full;
   assign pop_ok       = pop && !status.empty;
   assign wr_pos       = count_ff - CW'(pop_ok);
   assign count_in     = count_ff + CW'(push_ok) - CW'(pop_ok);
   assign head_job     = slot_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // each slot takes the new block at the write position, else shifts toward the head
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         if (push_ok && (wr_pos == CW'(i))) begin
            slot_ff[i] <= push_job;
         end else if (pop_ok) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
      if (push_ok && (wr_pos == CW'(DEPTH - 1))) begin
         slot_ff[DEPTH-1] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sbc_pkg::queue_status_type q_status,
   input  wire sbc_pkg::block_job_type    q_job,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_pop,
   output sbc_pkg::hash_type              rsp_hash
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_FINAL = 3'b100
   } back_state_type;

   localparam int HW = sbc_pkg::HASH_WORDS;

   back_state_type              state_ff, state_in;
   logic [sbc_pkg::ROUND_W-1:0] rnd_ff, rnd_in;
   sbc_pkg::hash_type           chain_ff, chain_in;
   sbc_pkg::hash_type           v_ff, v_in;
   sbc_pkg::block_type          w_ff, w_in;
   sbc_pkg::hash_type           hash_ff, hash_in;
   logic                        valid_ff, valid_in;
   sbc_pkg::hash_type           base;
   sbc_pkg::hash_type           sum;
   sbc_pkg::word_type           t1, t2, ch, maj, w_next;
   logic                        out_free;
   logic                        finish;

   assign out_free  = !valid_ff || rsp_pop;
   assign q_pop     = (state_ff == ST_IDLE) && !q_status.empty;
   assign finish    = (state_ff == ST_FINAL) && out_free;
   assign rsp_valid = valid_ff;
   assign rsp_hash  = hash_ff;

   // chaining value this block starts from
   assign base = q_job.reload ? sbc_pkg::INIT_HASH : chain_ff;

   // one compression round
   always_comb begin
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1  = v_ff[7] + sbc_pkg::big_sigma1(v_ff[4]) + ch + sbc_pkg::ROUND_K[rnd_ff] + w_ff[0];
      t2  = sbc_pkg::big_sigma0(v_ff[0]) + maj;
   end

   // next schedule word from the sliding 16-word window
   assign w_next = w_ff[0] + sbc_pkg::small_sigma0(w_ff[1]) + w_ff[9]
                   + sbc_pkg::small_sigma1(w_ff[14]);

   always_comb begin
      for (int i = 0; i < HW; i++) begin
         sum[i] = chain_ff[i] + v_ff[i];
      end
   end

   // sequencer: load, 64 rounds, add back into the chain
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      chain_in = chain_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      hash_in  = hash_ff;
      valid_in = valid_ff && !rsp_pop;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               chain_in = base;
               v_in     = base;
               w_in     = q_job.words;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < sbc_pkg::BLOCK_WORDS - 1; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[sbc_pkg::BLOCK_WORDS-1] = w_next;
            rnd_in = rnd_ff + sbc_pkg::ROUND_W'(1);
            if (rnd_ff == sbc_pkg::ROUND_W'(sbc_pkg::ROUNDS - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (finish) begin
               chain_in = sum;
               hash_in  = sum;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         chain_ff <= sbc_pkg::INIT_HASH;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
         valid_ff <= valid_in;
      end
   end

   // working variables, schedule window and result words
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      w_ff    <= w_in;
      hash_ff <= hash_in;
   end

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (rnd_ff == '0))
      else $error("round counter busy outside the round loop");

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == ST_FINAL))
      else $error("result appeared without a finished block");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=> $stable(hash_ff))
      else $error("waiting result overwritten");

endmodule

`default_nettype wire
